FILE: design/mtet_pkg.sv
// Shared constants, codes and types for the multi-turn encoder tracker.
// No dependencies; imported by every design module but mtet_checker.
package mtet_pkg;

	localparam int CountW      = 14;
	localparam int RawW        = 13;
	localparam int SumW        = 24;
	localparam int MagW        = 23;
	localparam int DivBits     = 34;
	localparam int DivCntW     = $clog2(DivBits + 1);

	localparam logic signed [15:0] CountsPerTurn = 16'sd8192;
	localparam logic signed [15:0] HalfTurn      = 16'sd4096;
	localparam logic [15:0]        MaxRaw        = 16'd8191;
	localparam logic [13:0]        VelScale      = 14'd11250;
	localparam logic [7:0]         IntervalReset = 8'd10;

	localparam logic [10:0] IdGimbal0 = 11'h205;
	localparam logic [10:0] IdGimbal1 = 11'h206;
	localparam logic [10:0] IdLoader  = 11'h207;

	localparam logic [1:0] MotorGimbal0 = 2'd0;
	localparam logic [1:0] MotorGimbal1 = 2'd1;
	localparam logic [1:0] MotorLoader  = 2'd2;

	localparam logic signed [31:0] VelMax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VelMin = 32'sh8000_0000;

	typedef struct packed {
		logic load;
		logic step;
		logic apply;
		logic mul;
		logic div_start;
		logic finish;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic need_vel;
		logic dt_zero;
		logic div_busy;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic               accepted;
		logic [1:0]         motor_index;
		logic signed [13:0] angle_counts;
		logic signed [31:0] turn_total;
		logic signed [31:0] velocity;
		logic               velocity_fresh;
		logic signed [15:0] measured_word;
	} result_t;

endpackage

FILE: design/mtet_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mtet_pkg for the dividend width.
module mtet_div
	import mtet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivBits-1:0] dividend,
	input  logic [31:0]        divisor,
	output logic               busy,
	output logic [DivBits-1:0] quotient
);

	logic [31:0]        rem_q;
	logic [DivBits-1:0] quo_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic [32:0]        trial;
	logic [32:0]        diff;
	logic               ge;

	assign trial = {rem_q, quo_q[DivBits-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DivCntW'(DivBits);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DivCntW'(1);
			if (cnt_q == DivCntW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[DivBits-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: design/mtet_ctrl.sv
// Sequencing state machine: step, state update, multiply, divide, result.
// Depends on mtet_pkg for command and status types.
module mtet_ctrl
	import mtet_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_STEP   = 8'b0000_0010,
		ST_APPLY  = 8'b0000_0100,
		ST_MUL    = 8'b0000_1000,
		ST_DSTART = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_FIN    = 8'b0100_0000,
		ST_PUSH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_STEP;
			ST_STEP:   state_d = ST_APPLY;
			ST_APPLY:  state_d = status.need_vel ? ST_MUL : ST_PUSH;
			ST_MUL:    state_d = status.dt_zero ? ST_FIN : ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (!status.div_busy) state_d = ST_FIN;
			ST_FIN:    state_d = ST_PUSH;
			ST_PUSH:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.step      = state_q == ST_STEP;
		cmd.apply     = state_q == ST_APPLY;
		cmd.mul       = state_q == ST_MUL;
		cmd.div_start = state_q == ST_DSTART;
		cmd.finish    = state_q == ST_FIN;
		cmd.push      = (state_q == ST_PUSH) && status.out_free;
	end

	assign s_tready = state_q == ST_IDLE;

endmodule

FILE: design/mtet_datapath.sv
// Per-motor state, step unwrap, velocity arithmetic and output register.
// Depends on mtet_pkg and mtet_div.
module mtet_datapath
	import mtet_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output status_t      status,
	input  logic [10:0]  in_frame_id,
	input  logic [15:0]  in_angle_raw,
	input  logic [15:0]  in_second_word,
	input  logic [31:0]  in_time_ms,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      out_res
);

	logic [7:0]  interval_q;

	logic [10:0]        id_q;
	logic [15:0]        raw_q;
	logic signed [15:0] word_q;
	logic [31:0]        time_q;

	logic [RawW-1:0]          prev_q [3];
	logic signed [CountW-1:0] wrap_q [3];
	logic signed [31:0]       turn_q [3];
	logic signed [SumW-1:0]   msum_q [2];
	logic [7:0]               samp_q [2];
	logic [31:0]              wstart_q [2];
	logic signed [31:0]       lvel_q [2];

	logic                     ok_q;
	logic [1:0]               m_q;
	logic signed [CountW-1:0] step_q;

	logic [MagW-1:0]    mag_q;
	logic               neg_q;
	logic [31:0]        dt_q;
	logic [DivBits-1:0] prod_q;
	result_t            res_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [1:0]               m_dec;
	logic                     ok_dec;
	logic signed [CountW-1:0] diff;
	logic signed [CountW-1:0] step_d;

	logic                     gi;
	logic signed [15:0]       asum;
	logic signed [CountW-1:0] angle_d;
	logic signed [31:0]       turn_d;
	logic signed [SumW-1:0]   sum_d;
	logic signed [SumW-1:0]   sum_neg;
	logic [7:0]               samp_d;
	logic                     need_vel;
	logic signed [31:0]       loader_vel;

	logic [36:0]        prod_full;
	logic               div_busy;
	logic [DivBits-1:0] quo;
	logic signed [31:0] vel_fin;

	always_comb begin
		case (id_q)
			IdGimbal0: begin m_dec = MotorGimbal0; ok_dec = 1'b1; end
			IdGimbal1: begin m_dec = MotorGimbal1; ok_dec = 1'b1; end
			IdLoader:  begin m_dec = MotorLoader;  ok_dec = 1'b1; end
			default:   begin m_dec = MotorGimbal0; ok_dec = 1'b0; end
		endcase
		if (raw_q > MaxRaw)
			ok_dec = 1'b0;
	end

	always_comb begin
		diff   = $signed({1'b0, raw_q[RawW-1:0]}) - $signed({1'b0, prev_q[m_dec]});
		step_d = diff;
		if (m_dec == MotorLoader) begin
			if (diff < 0)
				step_d = diff + CountW'(CountsPerTurn);
		end else if (diff < -CountW'(HalfTurn)) begin
			step_d = diff + CountW'(CountsPerTurn);
		end else if (diff > CountW'(HalfTurn)) begin
			step_d = diff - CountW'(CountsPerTurn);
		end else if (diff == CountW'(HalfTurn) || diff == -CountW'(HalfTurn)) begin
			step_d = (lvel_q[m_dec[0]] > 0) ? CountW'(HalfTurn) : -CountW'(HalfTurn);
		end
	end

	assign gi   = m_q[0];
	assign asum = 16'(wrap_q[m_q]) + 16'(step_q);

	always_comb begin
		angle_d = asum[CountW-1:0];
		turn_d  = turn_q[m_q];
		if (m_q == MotorLoader) begin
			if (asum >= CountsPerTurn) begin
				angle_d = CountW'(asum - CountsPerTurn);
				turn_d  = turn_q[m_q] + 32'sd1;
			end
		end else if (asum >= HalfTurn) begin
			angle_d = CountW'(asum - CountsPerTurn);
			turn_d  = turn_q[m_q] + 32'sd1;
		end else if (asum < -HalfTurn) begin
			angle_d = CountW'(asum + CountsPerTurn);
			turn_d  = turn_q[m_q] - 32'sd1;
		end
	end

	assign sum_d      = msum_q[gi] + SumW'(step_q);
	assign sum_neg    = -sum_d;
	assign samp_d     = samp_q[gi] + 8'd1;
	assign need_vel   = ok_q && (m_q != MotorLoader) && (samp_d >= interval_q);
	assign loader_vel = (32'(word_q) <<< 10) + (32'(word_q) <<< 9);

	assign prod_full = 37'(mag_q) * 37'(VelScale);

	always_comb begin
		if (status.dt_zero) begin
			if (neg_q)
				vel_fin = VelMin;
			else if (prod_q != '0)
				vel_fin = VelMax;
			else
				vel_fin = '0;
		end else if (neg_q) begin
			if (quo > DivBits'(34'h0_8000_0000))
				vel_fin = VelMin;
			else
				vel_fin = -$signed(quo[31:0]);
		end else if (quo[DivBits-1:31] != '0) begin
			vel_fin = VelMax;
		end else begin
			vel_fin = $signed(quo[31:0]);
		end
	end

	mtet_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dt_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IntervalReset;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				wrap_q[i] <= '0;
				turn_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				msum_q[i]   <= '0;
				samp_q[i]   <= '0;
				wstart_q[i] <= '0;
				lvel_q[i]   <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				interval_q <= cfg_wr_data;
			if (cmd.apply && ok_q) begin
				prev_q[m_q] <= raw_q[RawW-1:0];
				wrap_q[m_q] <= angle_d;
				turn_q[m_q] <= turn_d;
				if (m_q != MotorLoader) begin
					if (need_vel) begin
						msum_q[gi]   <= '0;
						samp_q[gi]   <= '0;
						wstart_q[gi] <= time_q;
					end else begin
						msum_q[gi] <= sum_d;
						samp_q[gi] <= samp_d;
					end
				end
			end
			if (cmd.finish)
				lvel_q[gi] <= vel_fin;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= in_frame_id;
			raw_q  <= in_angle_raw;
			word_q <= in_second_word;
			time_q <= in_time_ms;
		end
		if (cmd.step) begin
			ok_q   <= ok_dec;
			m_q    <= m_dec;
			step_q <= step_d;
		end
		if (cmd.apply) begin
			mag_q <= sum_d[SumW-1] ? sum_neg[MagW-1:0] : sum_d[MagW-1:0];
			neg_q <= sum_d[SumW-1];
			dt_q  <= time_q - wstart_q[gi];
			if (ok_q) begin
				res_q.accepted       <= 1'b1;
				res_q.motor_index    <= m_q;
				res_q.angle_counts   <= angle_d;
				res_q.turn_total     <= turn_d;
				res_q.measured_word  <= word_q;
				res_q.velocity       <= (m_q == MotorLoader) ? loader_vel : lvel_q[gi];
				res_q.velocity_fresh <= m_q == MotorLoader;
			end else begin
				res_q <= '0;
			end
		end
		if (cmd.mul)
			prod_q <= prod_full[DivBits-1:0];
		if (cmd.finish) begin
			res_q.velocity       <= vel_fin;
			res_q.velocity_fresh <= 1'b1;
		end
		if (cmd.push)
			out_q <= res_q;
	end

	always_comb begin
		status          = '0;
		status.need_vel = need_vel;
		status.dt_zero  = dt_q == '0;
		status.div_busy = div_busy;
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

FILE: design/multi_turn_encoder_tracker_top.sv
// Channel    | Dir | Width           | Content
// s_*        | in  | tdata 64, tuser 11 | motor feedback frame
// m_*        | out | tdata 96, tuser 4  | tracked angle, turns and velocity
// cfg_wr_*   | in  | 8               | sample_interval
// Top level of the multi-turn encoder tracker; depends on mtet_pkg,
// mtet_ctrl and mtet_datapath.
// A frame passes the step and apply states before its result is pushed
// (rejected frames, loader frames, gimbal frames that do not recompute
// velocity); when gimbal velocity is recomputed it also passes the multiply,
// divider start, restoring divide and finish states. A zero window time skips the divider.
// A new frame is taken while the previous result waits in the output register.
// Reset is asynchronous; all per-motor state clears at once.
module multi_turn_encoder_tracker_top
	import mtet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // angle_raw, second_word, time_ms
	input  logic [10:0] s_tuser,   // frame_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // angle_counts, turn_total, velocity, measured_word, pad
	output logic [3:0]  m_tuser,   // accepted, motor_index, velocity_fresh
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	cmd_t    cmd;
	status_t status;
	result_t res;

	mtet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mtet_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_frame_id    (s_tuser),
		.in_angle_raw   (s_tdata[15:0]),
		.in_second_word (s_tdata[31:16]),
		.in_time_ms     (s_tdata[63:32]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_res        (res)
	);

	assign m_tdata = {2'b00, res.measured_word, res.velocity, res.turn_total, res.angle_counts};
	assign m_tuser = {res.velocity_fresh, res.motor_index, res.accepted};

endmodule

FILE: design/mtet_checker.sv
// Port-level checks for the multi-turn encoder tracker, bound to the top.
// Depends on multi_turn_encoder_tracker_top.
module mtet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [3:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second frame taken while one is in work");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser == '0)
		else $error("rejected frame carries data");

	a_loader_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[2:1] == 2'd2 |-> m_tuser[3] && !m_tdata[13])
		else $error("loader result out of range or stale");

	a_gimbal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[2:1] != 2'd2 |->
			m_tuser[2:1] != 2'd3 && m_tdata[13] == m_tdata[12])
		else $error("gimbal angle out of half-turn range");

endmodule

bind multi_turn_encoder_tracker_top mtet_checker u_mtet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
